[rtl/fasc_pkg.sv]
`default_nettype none
package fasc_pkg;

  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int POOL_MAX_BYTES   = 65536;
  localparam int POOL_MIN_BYTES   = 32;
  localparam int SPLIT_SLACK      = 8;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;
  localparam logic [1:0] OP_INIT    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_NOINIT  = 3'd4;

  localparam logic REG_POOL_BYTES = 1'b0;
  localparam logic REG_FIT_POLICY = 1'b1;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_INSERT,
    CM_DELETE,
    CM_UPDATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     data;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DECIDE,
    S_SPLIT,
    S_SPLIT_UPD,
    S_FREE,
    S_ABS_UPD,
    S_ABS_DEL,
    S_MSCAN,
    S_MCHK,
    S_MUPD,
    S_MDEL,
    S_SSCAN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/fasc_cell.sv]
`default_nettype none
module fasc_cell import fasc_pkg::*; #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire cell_cmd_t  cmd,
  input  wire logic [IW-1:0] pos,
  input  wire entry_t     left,
  input  wire entry_t     right,
  output entry_t          ent
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  always_ff @(posedge clk) begin
    case (cmd.mode)
      CM_ROTATE: begin
        ent <= right;
      end
      CM_INSERT: begin
        if (ME > pos) begin
          ent <= left;
        end else if (ME == pos) begin
          ent <= cmd.data;
        end
      end
      CM_DELETE: begin
        if (ME >= pos) begin
          ent <= right;
        end
      end
      CM_UPDATE: begin
        if (ME == pos) begin
          ent <= cmd.data;
        end
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/fit_allocator_split_coalesce.sv]
`default_nettype none
// Pool allocator over an address-ordered segment table kept in a row of cells.
// Command channel: an operation (op, request_size, address) is taken when
// start is high and busy is low. One result per operation comes back on the
// output ports for exactly one cycle with done high; the receiver cannot
// stall, so the result must be taken in that cycle.
// Configuration: write_enable/write_index/write_data, index 0 pool_bytes,
// index 1 fit_policy; write only while busy is low.
// Each table lookup is one full rotation of the cell row. Init is a summary pass;
// alloc is a lookup pass, the split and a summary pass (no split when it fails);
// free is a lookup pass, the free, a merge pass and a summary pass, and a moving
// realloc does the split before the free. Each merged pair of free segments adds
// another merge pass. No new operation is taken until the last one is done.
// The row of cells shifts its entries each cycle while a pass runs; insert and
// delete are neighbor handoffs along the row.
// Reset clears the table count and the ready flag; the pool must be
// initialized with op 3 before other operations succeed.
module fit_allocator_split_coalesce import fasc_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [16:0] request_size,
  input  wire logic [15:0] address,
  input  wire logic        write_enable,
  input  wire logic        write_index,
  input  wire logic [16:0] write_data,
  output logic             done,
  output logic [2:0]       status,
  output logic [15:0]      result_address,
  output logic             moved,
  output logic [16:0]      free_bytes,
  output logic [16:0]      used_bytes,
  output logic [6:0]       free_segments,
  output logic [6:0]       total_segments
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [IW-1:0] T_LAST = IW'(MAX_SEGMENTS - 1);

  state_t state, state_next;

  logic [16:0] pool_bytes;
  logic        fit_policy;
  logic [CW-1:0] count;
  logic        ready;

  logic [1:0]  op_q;
  logic [16:0] want;
  logic [15:0] addr;
  logic [2:0]  status_q;
  logic [15:0] granted;
  logic        moved_q;
  logic        mv;

  logic [IW-1:0] t;
  logic        pk_f, fu_f, nx_f, mg_f;
  logic [IW-1:0] pk_i, fu_i, mg_i;
  logic [15:0] pk_start, mg_start, prev_start;
  logic [16:0] pk_size, fu_size, nx_size, mg_sum, prev_size;
  logic        nx_free, prev_free;
  logic [16:0] fb, ub;
  logic [CW-1:0] fs;

  logic [IW-1:0] sp_i, fr_i;
  logic [15:0] sp_start;
  logic [16:0] sp_size;
  logic        sp_ins;

  entry_t    cells [MAX_SEGMENTS];
  entry_t    lft [MAX_SEGMENTS];
  entry_t    rgt [MAX_SEGMENTS];
  cell_cmd_t cmd;
  logic [IW-1:0] pos;

  genvar j;
  generate
    for (j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
      if (j == 0) begin : g_l0
        assign lft[j] = cmd.data;
      end else begin : g_ln
        assign lft[j] = cells[j-1];
      end
      if (j == MAX_SEGMENTS - 1) begin : g_rl
        assign rgt[j] = cmd.data;
      end else begin : g_rn
        assign rgt[j] = cells[j+1];
      end
      fasc_cell #(.IW(IW), .IDX(j)) u_cell (
        .clk  (clk),
        .cmd  (cmd),
        .pos  (pos),
        .left (lft[j]),
        .right(rgt[j]),
        .ent  (cells[j])
      );
    end
  endgenerate

  // scan of the entry at the head of the row
  entry_t e;
  logic   scanning, first, live, last;
  logic   pk_hit, fu_hit, nx_hit, mg_hit;
  assign e        = cells[0];
  assign scanning = (state == S_SCAN) || (state == S_MSCAN) || (state == S_SSCAN);
  assign first    = (t == '0);
  assign last     = (t == T_LAST);
  assign live     = (CW'(t) < count);
  assign pk_hit   = live && e.free && (e.size >= want) &&
                    (first || !pk_f || (fit_policy && (e.size < pk_size)));
  assign fu_hit   = live && !e.free && (e.start == addr) && (first || !fu_f);
  assign nx_hit   = live && !first && fu_f && ({1'b0, t} == ({1'b0, fu_i} + 1'b1));
  assign mg_hit   = live && !first && prev_free && e.free && !mg_f;

  // init values
  logic [16:0] p1, p2, p3;
  always_comb begin
    p1 = (pool_bytes < 17'(POOL_MIN_BYTES)) ? 17'(POOL_MIN_BYTES) : pool_bytes;
    p2 = ({15'd0, p1} > 32'(POOL_MAX_BYTES)) ? 17'(POOL_MAX_BYTES) : p1;
    p3 = (p2 <= HDR17) ? 17'(HEADER_BYTES + 1) : p2;
  end

  logic [17:0] grow_sum;
  logic [16:0] abs_sum;
  logic        ins_now;
  assign grow_sum = {1'b0, fu_size} + {1'b0, HDR17} + {1'b0, nx_size};
  assign abs_sum  = grow_sum[16:0];
  assign ins_now  = (count < CNT_MAX) &&
                    ({1'b0, sp_size} > ({1'b0, want} + 18'(HEADER_BYTES + SPLIT_SLACK)));

  // decision after the lookup pass
  state_t      dec_next;
  logic [2:0]  dec_status;
  logic        dec_use_pick, dec_grant_addr, dec_mv;
  logic        alloc_path;
  assign alloc_path = (op_q == OP_ALLOC) || ((op_q == OP_REALLOC) && (addr == '0));

  always_comb begin
    dec_next       = S_SSCAN;
    dec_status     = ST_OK;
    dec_use_pick   = 1'b0;
    dec_grant_addr = 1'b0;
    dec_mv         = 1'b0;
    if (alloc_path) begin
      if (want == '0) begin
        dec_status = ST_ZERO;
      end else if (!pk_f) begin
        dec_status = ST_NOSPACE;
      end else begin
        dec_use_pick = 1'b1;
        dec_next     = S_SPLIT;
      end
    end else if (op_q == OP_FREE) begin
      if (addr == '0) begin
        dec_next = S_SSCAN;
      end else if (!fu_f) begin
        dec_status = ST_BADADDR;
      end else begin
        dec_next = S_FREE;
      end
    end else begin
      if (!fu_f) begin
        dec_status = ST_BADADDR;
      end else if (want == '0) begin
        dec_next = S_FREE;
      end else if (fu_size >= want) begin
        dec_grant_addr = 1'b1;
        dec_next       = S_SPLIT;
      end else if (nx_f && nx_free && (grow_sum >= {1'b0, want})) begin
        dec_grant_addr = 1'b1;
        dec_next       = S_ABS_UPD;
      end else if (!pk_f) begin
        dec_status = ST_NOSPACE;
      end else begin
        dec_use_pick = 1'b1;
        dec_mv       = 1'b1;
        dec_next     = S_SPLIT;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_INIT) begin
            state_next = S_INIT;
          end else if (!ready) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_INIT:      state_next = S_SSCAN;
      S_SCAN:      state_next = last ? S_DECIDE : S_SCAN;
      S_DECIDE:    state_next = dec_next;
      S_SPLIT:     state_next = S_SPLIT_UPD;
      S_SPLIT_UPD: state_next = mv ? S_FREE : S_SSCAN;
      S_FREE:      state_next = S_MSCAN;
      S_ABS_UPD:   state_next = S_ABS_DEL;
      S_ABS_DEL:   state_next = S_SPLIT;
      S_MSCAN:     state_next = last ? S_MCHK : S_MSCAN;
      S_MCHK:      state_next = mg_f ? S_MUPD : S_SSCAN;
      S_MUPD:      state_next = S_MDEL;
      S_MDEL:      state_next = S_MSCAN;
      S_SSCAN:     state_next = last ? S_DONE : S_SSCAN;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.mode = CM_HOLD;
    cmd.data = e;
    pos      = '0;
    case (state)
      S_SCAN, S_MSCAN, S_SSCAN: begin
        cmd.mode = CM_ROTATE;
      end
      S_INIT: begin
        cmd.mode = CM_UPDATE;
        cmd.data = '{start: 16'(HEADER_BYTES), size: 17'(p3 - HDR17), free: 1'b1};
      end
      S_SPLIT: begin
        if (ins_now) begin
          cmd.mode = CM_INSERT;
          pos      = IW'({1'b0, sp_i} + 1'b1);
          cmd.data = '{start: 16'(17'(sp_start) + want + HDR17),
                       size: 17'(sp_size - want - HDR17), free: 1'b1};
        end
      end
      S_SPLIT_UPD: begin
        cmd.mode = CM_UPDATE;
        pos      = sp_i;
        cmd.data = '{start: sp_start, size: (sp_ins ? want : sp_size), free: 1'b0};
      end
      S_FREE: begin
        cmd.mode = CM_UPDATE;
        pos      = fr_i;
        cmd.data = '{start: addr, size: fu_size, free: 1'b1};
      end
      S_ABS_UPD: begin
        cmd.mode = CM_UPDATE;
        pos      = fu_i;
        cmd.data = '{start: addr, size: abs_sum, free: 1'b0};
      end
      S_ABS_DEL: begin
        cmd.mode = CM_DELETE;
        pos      = IW'({1'b0, fu_i} + 1'b1);
      end
      S_MUPD: begin
        cmd.mode = CM_UPDATE;
        pos      = mg_i;
        cmd.data = '{start: mg_start, size: mg_sum, free: 1'b1};
      end
      S_MDEL: begin
        cmd.mode = CM_DELETE;
        pos      = IW'({1'b0, mg_i} + 1'b1);
      end
      default: begin
        cmd.mode = CM_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ready      <= 1'b0;
      pool_bytes <= 17'(POOL_MAX_BYTES);
      fit_policy <= 1'b0;
      t          <= '0;
    end else begin
      state <= state_next;
      if (write_enable) begin
        if (write_index == REG_POOL_BYTES) begin
          pool_bytes <= write_data;
        end else begin
          fit_policy <= write_data[0];
        end
      end
      if (scanning) begin
        t <= last ? '0 : t + 1'b1;
      end
      case (state)
        S_INIT: begin
          count <= CW'(1);
          ready <= 1'b1;
        end
        S_SPLIT: begin
          if (ins_now) begin
            count <= count + 1'b1;
          end
        end
        S_ABS_DEL, S_MDEL: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q     <= op;
      want     <= request_size;
      addr     <= address;
      status_q <= (ready || op == OP_INIT) ? ST_OK : ST_NOINIT;
      granted  <= '0;
      moved_q  <= 1'b0;
      mv       <= 1'b0;
    end
    if (scanning) begin
      if (pk_hit) begin
        pk_f     <= 1'b1;
        pk_i     <= t;
        pk_start <= e.start;
        pk_size  <= e.size;
      end else if (first) begin
        pk_f <= 1'b0;
      end
      if (fu_hit) begin
        fu_f    <= 1'b1;
        fu_i    <= t;
        fu_size <= e.size;
      end else if (first) begin
        fu_f <= 1'b0;
      end
      if (nx_hit) begin
        nx_f    <= 1'b1;
        nx_free <= e.free;
        nx_size <= e.size;
      end else if (first) begin
        nx_f <= 1'b0;
      end
      if (mg_hit) begin
        mg_f     <= 1'b1;
        mg_i     <= IW'(t - 1'b1);
        mg_start <= prev_start;
        mg_sum   <= 17'(prev_size + HDR17 + e.size);
      end else if (first) begin
        mg_f <= 1'b0;
      end
      prev_free  <= live && e.free;
      prev_start <= e.start;
      prev_size  <= e.size;
      fb <= (first ? 17'd0 : fb) + ((live && e.free) ? e.size : 17'd0);
      ub <= (first ? 17'd0 : ub) + ((live && !e.free) ? e.size : 17'd0);
      fs <= (first ? '0 : fs) + CW'(live && e.free);
    end
    case (state)
      S_DECIDE: begin
        status_q <= dec_status;
        mv       <= dec_mv;
        moved_q  <= dec_mv;
        fr_i     <= fu_i;
        if (dec_use_pick) begin
          sp_i     <= pk_i;
          sp_start <= pk_start;
          sp_size  <= pk_size;
          granted  <= pk_start;
        end else begin
          sp_i     <= fu_i;
          sp_start <= addr;
          sp_size  <= fu_size;
          if (dec_grant_addr) begin
            granted <= addr;
          end
        end
      end
      S_SPLIT: begin
        sp_ins <= ins_now;
      end
      S_SPLIT_UPD: begin
        fr_i <= (sp_ins && (sp_i < fu_i)) ? IW'({1'b0, fu_i} + 1'b1) : fu_i;
      end
      S_ABS_DEL: begin
        sp_size <= abs_sum;
      end
      default: begin
        sp_ins <= sp_ins;
      end
    endcase
  end

  assign busy           = (state != S_IDLE);
  assign done           = (state == S_DONE);
  assign status         = status_q;
  assign result_address = granted;
  assign moved          = moved_q;
  assign free_bytes     = ready ? fb : 17'd0;
  assign used_bytes     = ready ? ub : 17'd0;
  assign free_segments  = ready ? 7'(fs) : 7'd0;
  assign total_segments = ready ? 7'(count) : 7'd0;

endmodule
`default_nettype wire

[dv/alloc_checker.sv]
`default_nettype none
module alloc_checker import fasc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  op,
  input  wire logic [16:0] request_size,
  input  wire logic [15:0] address,
  input  wire logic        write_enable,
  input  wire logic        write_index,
  input  wire logic [16:0] write_data,
  input  wire logic        done,
  input  wire logic [2:0]  status,
  input  wire logic [15:0] result_address,
  input  wire logic        moved,
  input  wire logic [16:0] free_bytes,
  input  wire logic [16:0] used_bytes,
  input  wire logic [6:0]  free_segments,
  input  wire logic [6:0]  total_segments,
  output int               fails,
  output int               pending
);

  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int NSEG = MAX_SEGMENTS_DEF;

  typedef struct {
    logic [2:0]  st;
    logic [15:0] addr;
    logic        mv;
    logic [16:0] fb;
    logic [16:0] ub;
    logic [6:0]  fs;
    logic [6:0]  ts;
  } outcome_t;

  outcome_t expected_q[$];

  int unsigned pool_cfg;
  bit          best_fit;
  int unsigned seg_start [NSEG];
  int unsigned seg_size  [NSEG];
  bit          seg_free  [NSEG];
  int unsigned nseg;
  bit          ready;

  function automatic void split_seg(int unsigned i, int unsigned want);
    if (i >= nseg || nseg >= NSEG) return;
    if (seg_size[i] <= want + HDR + SPLIT_SLACK) return;
    for (int unsigned k = nseg; k > i + 1; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_size[k]  = seg_size[k-1];
      seg_free[k]  = seg_free[k-1];
    end
    seg_start[i+1] = seg_start[i] + want + HDR;
    seg_size[i+1]  = seg_size[i] - want - HDR;
    seg_free[i+1]  = 1'b1;
    seg_size[i]    = want;
    nseg++;
  endfunction

  function automatic void absorb_seg(int unsigned i);
    if (i + 1 >= nseg) return;
    seg_size[i] += HDR + seg_size[i+1];
    for (int unsigned k = i + 1; k + 1 < nseg; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k]  = seg_size[k+1];
      seg_free[k]  = seg_free[k+1];
    end
    nseg--;
  endfunction

  function automatic void coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < nseg) begin
      if (seg_free[i] && seg_free[i+1]) absorb_seg(i);
      else i++;
    end
  endfunction

  function automatic int unsigned find_owned(int unsigned a);
    for (int unsigned i = 0; i < nseg; i++)
      if (!seg_free[i] && seg_start[i] == a) return i;
    return nseg;
  endfunction

  function automatic logic [2:0] grant(int unsigned want, output int unsigned where);
    int unsigned pick;
    pick = nseg;
    where = 0;
    if (want == 0) return ST_ZERO;
    for (int unsigned i = 0; i < nseg; i++) begin
      if (!seg_free[i] || seg_size[i] < want) continue;
      if (pick == nseg || seg_size[i] < seg_size[pick]) pick = i;
      if (!best_fit) break;
    end
    if (pick == nseg) return ST_NOSPACE;
    split_seg(pick, want);
    seg_free[pick] = 1'b0;
    where = seg_start[pick];
    return ST_OK;
  endfunction

  function automatic outcome_t predict_alloc(logic [1:0] o, int unsigned want, int unsigned a);
    outcome_t r;
    int unsigned i, p, g, fb, ub, fs;
    r.st = ST_OK; r.mv = 1'b0; g = 0; fb = 0; ub = 0; fs = 0;
    if (o == OP_INIT) begin
      p = pool_cfg;
      if (p < POOL_MIN_BYTES) p = POOL_MIN_BYTES;
      if (p > POOL_MAX_BYTES) p = POOL_MAX_BYTES;
      if (p <= HDR) p = HDR + 1;
      seg_start[0] = HDR;
      seg_size[0]  = p - HDR;
      seg_free[0]  = 1'b1;
      nseg = 1;
      ready = 1'b1;
    end else if (!ready) begin
      r.st = ST_NOINIT;
    end else if (o == OP_ALLOC || (o == OP_REALLOC && a == 0)) begin
      r.st = grant(want, g);
    end else if (o == OP_FREE) begin
      if (a != 0) begin
        i = find_owned(a);
        if (i == nseg) r.st = ST_BADADDR;
        else begin
          seg_free[i] = 1'b1;
          coalesce();
        end
      end
    end else begin
      i = find_owned(a);
      if (i == nseg) r.st = ST_BADADDR;
      else if (want == 0) begin
        seg_free[i] = 1'b1;
        coalesce();
      end else if (seg_size[i] >= want) begin
        split_seg(i, want);
        g = a;
      end else if (i + 1 < nseg && seg_free[i+1] &&
                   seg_size[i] + HDR + seg_size[i+1] >= want) begin
        absorb_seg(i);
        split_seg(i, want);
        g = a;
      end else begin
        r.st = grant(want, g);
        if (r.st == ST_OK) begin
          r.mv = 1'b1;
          i = find_owned(a);
          if (i < nseg) begin
            seg_free[i] = 1'b1;
            coalesce();
          end
        end
      end
    end
    if (ready)
      for (i = 0; i < nseg; i++)
        if (seg_free[i]) begin
          fb += seg_size[i];
          fs++;
        end else ub += seg_size[i];
    r.addr = g[15:0];
    r.fb = fb[16:0];
    r.ub = ub[16:0];
    r.fs = fs[6:0];
    r.ts = ready ? nseg[6:0] : 7'd0;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      pool_cfg = POOL_MAX_BYTES;
      best_fit = 1'b0;
      nseg = 0;
      ready = 1'b0;
      expected_q.delete();
    end else begin
      if (write_enable) begin
        if (write_index == REG_POOL_BYTES) pool_cfg = write_data;
        else best_fit = write_data[0];
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d addr %0d", $time, status,
                   result_address);
          fails++;
        end else begin
          e = expected_q.pop_front();
          check_field("status", e.st, status);
          check_field("result_address", e.addr, result_address);
          check_field("moved", e.mv, moved);
          check_field("free_bytes", e.fb, free_bytes);
          check_field("used_bytes", e.ub, used_bytes);
          check_field("free_segments", e.fs, free_segments);
          check_field("total_segments", e.ts, total_segments);
        end
      end
      if (start && !busy) expected_q.push_back(predict_alloc(op, request_size, address));
    end
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
  import fasc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  op = OP_ALLOC;
  logic [16:0] request_size = '0;
  logic [15:0] address = '0;
  logic        write_enable = 1'b0;
  logic        write_index = REG_POOL_BYTES;
  logic [16:0] write_data = '0;
  logic        busy, done, moved;
  logic [2:0]  status;
  logic [15:0] result_address;
  logic [16:0] free_bytes, used_bytes;
  logic [6:0]  free_segments, total_segments;
  int          fails, pending;
  int          cycles = 0;
  bit          idling = 1'b1;
  logic [15:0] live_q[$];

  always #4 clk = ~clk;

  fit_allocator_split_coalesce dut (.*);
  alloc_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk)
    if (done && status == ST_OK && result_address != 0) live_q.push_back(result_address);

  task automatic drop_live(logic [15:0] a);
    foreach (live_q[i])
      if (live_q[i] == a) begin
        live_q.delete(i);
        return;
      end
  endtask

  task automatic send(logic [1:0] o, logic [16:0] s, logic [15:0] a);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    request_size <= s;
    address <= a;
    if (o == OP_INIT) live_q.delete();
    else if (o != OP_ALLOC) drop_live(a);
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    drain();
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_addr();
    if (live_q.size() != 0 && $urandom_range(0, 99) < 85)
      return live_q[$urandom_range(0, live_q.size() - 1)];
    if ($urandom_range(0, 9) == 0) return 16'd0;
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 17'd0;
    if (r < 8) return 17'($urandom_range(0, 65536));
    if (r < 40) return 17'($urandom_range(1, 48));
    return 17'($urandom_range(1, 900));
  endfunction

  initial begin
    int unsigned r;
    logic [16:0] pools[6];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(OP_ALLOC, 17'd10, 16'd0);
    send(OP_FREE, 17'd0, 16'd16);
    send(OP_REALLOC, 17'd5, 16'd16);
    write_reg(REG_POOL_BYTES, 17'd0);
    write_reg(REG_FIT_POLICY, 17'd0);
    send(OP_INIT, 17'd0, 16'd0);
    send(OP_ALLOC, 17'd1, 16'd0);
    send(OP_ALLOC, 17'd1, 16'd0);
    write_reg(REG_POOL_BYTES, 17'h1ffff);
    send(OP_INIT, 17'h1ffff, 16'hffff);
    send(OP_ALLOC, 17'd0, 16'd0);
    send(OP_ALLOC, 17'd65536, 16'd0);
    send(OP_ALLOC, 17'd100, 16'd0);
    send(OP_ALLOC, 17'd200, 16'd0);
    send(OP_ALLOC, 17'd300, 16'd0);
    send(OP_FREE, 17'd0, 16'hffff);
    send(OP_FREE, 17'd0, 16'd0);
    send(OP_REALLOC, 17'd50, 16'd0);
    send(OP_FREE, 17'd0, 16'd16);
    send(OP_FREE, 17'd0, 16'd16);
    send(OP_REALLOC, 17'd10, 16'd348);
    send(OP_REALLOC, 17'd400, 16'd132);
    send(OP_REALLOC, 17'd30, 16'd348);
    send(OP_REALLOC, 17'd0, 16'd348);
    write_reg(REG_FIT_POLICY, 17'd1);

    pools = '{17'd65536, 17'd65536, 17'd4096, 17'd32, 17'd2000, 17'd65536};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) pools[ph] = 17'($urandom_range(0, 131071));
      write_reg(REG_POOL_BYTES, pools[ph]);
      write_reg(REG_FIT_POLICY, 17'(ph % 2));
      idling = (ph < 5);
      send(OP_INIT, 17'($urandom), 16'($urandom));
      for (int n = 0; n < 180; n++) begin
        if (n == 90) drain();
        r = $urandom_range(0, 99);
        if (r < 45) send(OP_ALLOC, pick_size(), 16'($urandom));
        else if (r < 73) send(OP_FREE, 17'($urandom), pick_addr());
        else if (r < 98) send(OP_REALLOC, pick_size(), pick_addr());
        else send(OP_INIT, 17'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/fasc_pkg.sv
rtl/fasc_cell.sv
rtl/fit_allocator_split_coalesce.sv
dv/alloc_checker.sv
dv/tb_top.sv
